>>> src/pn_pkg.sv
// Shared types, sizes and byte codes of the path normalizer.
package pn_pkg;

   localparam int PATH_BYTES  = 64;
   localparam int MAX_DEPTH   = 32;
   localparam int QUEUE_DEPTH = 4;   // power of two, pointers wrap freely

   localparam int LEN_W  = $clog2(PATH_BYTES + 1);
   localparam int SUM_W  = LEN_W + 1;
   localparam int ADDR_W = $clog2(PATH_BYTES);
   localparam int DEP_W  = $clog2(MAX_DEPTH + 1);
   localparam int SIDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QIDX_W + 1;

   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DEP_W-1:0]  dep_type;
   typedef logic [SIDX_W-1:0] sidx_type;

   localparam len_type PB_LEN   = LEN_W'(PATH_BYTES);
   localparam sum_type PB_SUM   = SUM_W'(PATH_BYTES);
   localparam dep_type MAXD_DEP = DEP_W'(MAX_DEPTH);
   localparam len_type LEN_ONE  = LEN_W'(1);

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_NONE   = 8'h00;

   // one classified path byte in the queue
   typedef struct packed {
      logic       sep;
      logic [7:0] ch;
      logic       last;
   } item_type;

   // tag of a byte on its way out
   typedef struct packed {
      logic first;
      logic err;
      logic fin;
   } tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_FINISH,
      ST_EMIT
   } back_state_type;

endpackage

>>> src/path_normalizer.sv
// Top level of the path normalizer: front queue plus back-end engine.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   req_ch[7:0], req_last
//   rsp_      out        rsp_valid/rsp_stall   rsp_out_ch[7:0], rsp_error, rsp_final_res
//
// The back end takes one queued byte per cycle while idle; a ".." that pops the stack
// adds ST_POP for the stack memory read, and after the last byte ST_FINISH closes the
// path. Emission then streams out_len bytes at one per cycle while not stalled, from the
// buffer's read port, or one error item. A four-item queue accepts until full while the
// back end works. Reset is synchronous and clears all control state; buffer and stack
// contents need no clearing. Stalls on rsp_ hold the output register and the read stage.
module path_normalizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_ch,
   output logic       rsp_error,
   output logic       rsp_final_res
);

   // queue head as seen by the back end
   logic              q_valid;
   logic              q_pop;
   pn_pkg::item_type  q_item;

   // front: separator classification and item queue
   pn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .req_stall (req_stall),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // back: component tracking, stack, buffer, emission
   pn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_ch    (rsp_out_ch),
      .rsp_error     (rsp_error),
      .rsp_final_res (rsp_final_res)
   );

endmodule

>>> src/pn_front.sv
// Front end: classifies incoming path bytes and queues them for the back end.
module pn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_ch,
   input  logic              req_last,
   output logic              req_stall,
   output logic              q_valid,
   output pn_pkg::item_type  q_item,
   input  logic              q_pop
);

   pn_pkg::item_type                entries_ff [pn_pkg::QUEUE_DEPTH];
   logic [pn_pkg::QIDX_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pn_pkg::QIDX_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pn_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                            push;
   logic                            pop;
   pn_pkg::item_type                new_item;

   assign req_stall = (count_ff == pn_pkg::QCNT_W'(pn_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      new_item.sep  = (req_ch == pn_pkg::CH_SLASH) || (req_ch == pn_pkg::CH_BSLASH);
      new_item.ch   = req_ch;
      new_item.last = req_last;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> src/pn_back.sv
// Back end: component stack, output buffer and result emission.
module pn_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pn_pkg::item_type  q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_ch,
   output logic              rsp_error,
   output logic              rsp_final_res
);

   logic [7:0]                buf_mem   [pn_pkg::PATH_BYTES];
   pn_pkg::len_type           stack_mem [pn_pkg::MAX_DEPTH];

   pn_pkg::back_state_type    state_ff, state_in;
   pn_pkg::len_type           out_len_ff, out_len_in;
   pn_pkg::len_type           comp_len_ff, comp_len_in;
   pn_pkg::len_type           comp_org_ff, comp_org_in;
   logic [1:0]                dots_ff, dots_in;
   pn_pkg::dep_type           depth_ff, depth_in;
   logic                      err_ff, err_in;
   logic                      last_ff, last_in;
   pn_pkg::len_type           k_ff, k_in;

   // read stage and output register
   logic                      st_valid_ff, st_valid_in;
   pn_pkg::tag_type           st_tag_ff;
   pn_pkg::tag_type           st_tag_in;
   logic [7:0]                rdata_ff;
   pn_pkg::len_type           stack_rd_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_ch_ff;
   logic                      rsp_err_ff;
   logic                      rsp_fin_ff;

   logic                      out_free;
   logic                      issue;
   logic                      ec_do;
   logic                      ap_do;
   logic                      buf_we;
   pn_pkg::addr_type          buf_addr;
   logic [7:0]                buf_data;
   logic                      stack_we;
   logic                      stack_re;
   pn_pkg::sidx_type          stack_addr;
   pn_pkg::len_type           stack_data;

   // end-of-component terms
   logic                      ec_drop;
   logic                      ec_dotdot;
   logic                      ec_root;
   logic                      ec_slash_over;
   pn_pkg::sum_type           ec_o1;
   pn_pkg::sum_type           ec_end;
   pn_pkg::dep_type           depth_dec;

   // append terms
   pn_pkg::len_type           ap_org;
   pn_pkg::sum_type           ap_pos;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ec_drop       = (comp_len_ff == '0) || ((comp_len_ff == pn_pkg::LEN_ONE) && dots_ff[0]);
      ec_dotdot     = (comp_len_ff == pn_pkg::LEN_W'(2)) && (dots_ff == 2'b11);
      ec_root       = !(out_len_ff > pn_pkg::LEN_ONE);
      ec_slash_over = !ec_root &&
                      ((pn_pkg::SUM_W'(out_len_ff) + pn_pkg::SUM_W'(1)) >= pn_pkg::PB_SUM);
      ec_o1         = ec_root ? pn_pkg::SUM_W'(out_len_ff)
                              : pn_pkg::SUM_W'(out_len_ff) + pn_pkg::SUM_W'(1);
      ec_end        = ec_o1 + pn_pkg::SUM_W'(comp_len_ff);
      depth_dec     = depth_ff - 1'b1;
      ap_org        = (comp_len_ff == '0) ? out_len_ff : comp_org_ff;
      ap_pos        = pn_pkg::SUM_W'(ap_org) +
                      pn_pkg::SUM_W'(ap_org > pn_pkg::LEN_ONE) +
                      pn_pkg::SUM_W'(comp_len_ff);
   end

   always_comb begin
      state_in    = state_ff;
      out_len_in  = out_len_ff;
      comp_len_in = comp_len_ff;
      comp_org_in = comp_org_ff;
      dots_in     = dots_ff;
      depth_in    = depth_ff;
      err_in      = err_ff;
      last_in     = last_ff;
      k_in        = k_ff;
      q_pop       = 1'b0;
      issue       = 1'b0;
      ec_do       = 1'b0;
      ap_do       = 1'b0;
      buf_we      = 1'b0;
      buf_addr    = '0;
      buf_data    = pn_pkg::CH_SLASH;
      stack_we    = 1'b0;
      stack_re    = 1'b0;
      stack_addr  = '0;
      stack_data  = '0;
      st_tag_in.first = (k_ff == '0);
      st_tag_in.err   = err_ff;
      st_tag_in.fin   = err_ff || ((k_ff + pn_pkg::LEN_ONE) == out_len_ff);

      unique case (state_ff)
         pn_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               last_in = q_item.last;
               if (!err_ff) begin
                  if (q_item.sep) begin
                     ec_do = 1'b1;
                  end else begin
                     ap_do = 1'b1;
                  end
               end
               state_in = q_item.last ? pn_pkg::ST_FINISH : pn_pkg::ST_IDLE;
            end
         end
         pn_pkg::ST_POP: begin
            out_len_in = (stack_rd_ff == '0) ? pn_pkg::LEN_ONE : stack_rd_ff;
            state_in   = last_ff ? pn_pkg::ST_FINISH : pn_pkg::ST_IDLE;
         end
         pn_pkg::ST_FINISH: begin
            ec_do    = !err_ff;
            state_in = pn_pkg::ST_EMIT;
         end
         pn_pkg::ST_EMIT: begin
            issue = !st_valid_ff || out_free;
            if (issue) begin
               if (st_tag_in.fin) begin
                  // path done: back to the empty root state
                  out_len_in  = pn_pkg::LEN_ONE;
                  comp_len_in = '0;
                  comp_org_in = pn_pkg::LEN_ONE;
                  dots_in     = 2'b00;
                  depth_in    = '0;
                  err_in      = 1'b0;
                  last_in     = 1'b0;
                  k_in        = '0;
                  state_in    = pn_pkg::ST_IDLE;
               end else begin
                  k_in = k_ff + pn_pkg::LEN_ONE;
               end
            end
         end
         default: begin
            state_in = pn_pkg::ST_IDLE;
         end
      endcase

      if (ap_do) begin
         comp_org_in = ap_org;
         if (ap_pos < pn_pkg::PB_SUM) begin
            buf_we   = 1'b1;
            buf_addr = ap_pos[pn_pkg::ADDR_W-1:0];
            buf_data = q_item.ch;
         end
         if (q_item.ch == pn_pkg::CH_DOT) begin
            if (comp_len_ff == '0) begin
               dots_in = dots_ff | 2'b01;
            end else if (comp_len_ff == pn_pkg::LEN_ONE) begin
               dots_in = dots_ff | 2'b10;
            end
         end
         if (comp_len_ff < pn_pkg::PB_LEN) begin
            comp_len_in = comp_len_ff + pn_pkg::LEN_ONE;
         end
      end

      if (ec_do) begin
         comp_len_in = '0;
         dots_in     = 2'b00;
         priority if (ec_drop) begin
            // empty or "." component: nothing kept
         end else if (ec_dotdot) begin
            if (depth_ff != '0) begin
               depth_in   = depth_dec;
               stack_re   = 1'b1;
               stack_addr = depth_dec[pn_pkg::SIDX_W-1:0];
               state_in   = pn_pkg::ST_POP;
            end
         end else if (depth_ff >= pn_pkg::MAXD_DEP) begin
            err_in = 1'b1;
         end else if (ec_slash_over) begin
            err_in = 1'b1;
         end else begin
            if (!ec_root) begin
               buf_we   = 1'b1;
               buf_addr = out_len_ff[pn_pkg::ADDR_W-1:0];
               buf_data = pn_pkg::CH_SLASH;
            end
            stack_we   = 1'b1;
            stack_addr = depth_ff[pn_pkg::SIDX_W-1:0];
            stack_data = ec_root ? pn_pkg::LEN_ONE : out_len_ff;
            depth_in   = depth_ff + 1'b1;
            if (ec_end >= pn_pkg::PB_SUM) begin
               err_in = 1'b1;
            end else begin
               out_len_in = ec_end[pn_pkg::LEN_W-1:0];
            end
         end
      end

      st_valid_in  = issue || (st_valid_ff && !out_free);
      rsp_valid_in = out_free ? st_valid_ff : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pn_pkg::ST_IDLE;
         out_len_ff   <= pn_pkg::LEN_ONE;
         comp_len_ff  <= '0;
         comp_org_ff  <= pn_pkg::LEN_ONE;
         dots_ff      <= 2'b00;
         depth_ff     <= '0;
         err_ff       <= 1'b0;
         last_ff      <= 1'b0;
         k_ff         <= '0;
         st_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_len_ff   <= out_len_in;
         comp_len_ff  <= comp_len_in;
         comp_org_ff  <= comp_org_in;
         dots_ff      <= dots_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         last_ff      <= last_in;
         k_ff         <= k_in;
         st_valid_ff  <= st_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_addr] <= buf_data;
      end
      if (issue) begin
         rdata_ff  <= buf_mem[k_ff[pn_pkg::ADDR_W-1:0]];
         st_tag_ff <= st_tag_in;
      end
   end

   // component start stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_addr] <= stack_data;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && st_valid_ff) begin
         rsp_ch_ff  <= st_tag_ff.err   ? pn_pkg::CH_NONE :
                       st_tag_ff.first ? pn_pkg::CH_SLASH : rdata_ff;
         rsp_err_ff <= st_tag_ff.err;
         rsp_fin_ff <= st_tag_ff.fin;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_ch    = rsp_ch_ff;
   assign rsp_error     = rsp_err_ff;
   assign rsp_final_res = rsp_fin_ff;

endmodule

>>> src/pn_checker.sv
// Port-level checker for the path normalizer and its bind.
module pn_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_ch,
   input logic       rsp_error,
   input logic       rsp_final_res
);

   // high while the next result opens a new path
   logic sop_ff, sop_in;

   always_comb begin
      sop_in = sop_ff;
      if (rsp_valid && !rsp_stall) begin
         sop_in = rsp_final_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sop_ff <= 1'b1;
      end else begin
         sop_ff <= sop_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_ch) &&
                                 $stable(rsp_error) && $stable(rsp_final_res))
      else $error("stalled result changed");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_final_res && (rsp_out_ch == pn_pkg::CH_NONE) && sop_ff)
      else $error("malformed error item");

   a_lead_slash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sop_ff && !rsp_error |-> rsp_out_ch == pn_pkg::CH_SLASH)
      else $error("path does not start with slash");

   a_no_bslash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_out_ch != pn_pkg::CH_BSLASH)
      else $error("backslash in normalized path");

endmodule

bind path_normalizer pn_checker u_pn_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_ch    (rsp_out_ch),
   .rsp_error     (rsp_error),
   .rsp_final_res (rsp_final_res)
);

>>> bench/path_normalizer_tb.sv
// Self-checking testbench for the streaming path normalizer.
module path_normalizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int DRAIN_CYCLES = 16;     // closing cycles plus read stage, with margin
   localparam int MIXED_ITEMS  = 100;

   typedef logic [7:0] path_q_type[$];

   // one byte of a normalized path as it should leave the block
   typedef struct {
      logic [7:0] out_ch;
      logic       error;
      logic       fin;
   } path_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_ch;
   logic       rsp_error;
   logic       rsp_final_res;

   int error_count = 0;
   int cycle_count = 0;
   bit idle_on = 1'b1;      // random gaps and stalls; cleared for the last stretch
   int stall_left = 0;

   path_byte_type pending_path_bytes[$];

   // predictor state: normalized bytes so far and the component being built
   logic [7:0] norm_buf[pn_pkg::PATH_BYTES];
   int         norm_len;
   int         cut_stack[pn_pkg::MAX_DEPTH];
   int         kept_depth;
   int         seg_len;
   int         seg_start;
   logic [1:0] dot_bits;    // bit0: first byte is a dot, bit1: second byte is a dot
   logic       path_bad;

   path_normalizer i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_ch    (rsp_out_ch),
      .rsp_error     (rsp_error),
      .rsp_final_res (rsp_final_res)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic flag_error(string what);
      $display("ERROR @%0t: %s", $realtime, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         flag_error($sformatf("timeout after %0d cycles, %0d bytes still expected",
                              cycle_count, pending_path_bytes.size()));
         $display("path_normalizer_tb: done, errors");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic void clear_norm_path();
      norm_buf[0] = pn_pkg::CH_SLASH;
      norm_len    = 1;
      kept_depth  = 0;
      seg_len     = 0;
      seg_start   = 1;
      dot_bits    = 2'b00;
      path_bad    = 1'b0;
   endfunction

   function automatic void seg_add(logic [7:0] ch);
      int pos;
      if (seg_len == 0)
         seg_start = norm_len;
      pos = seg_start + ((seg_start > 1) ? 1 : 0) + seg_len;
      if (pos < pn_pkg::PATH_BYTES)
         norm_buf[pos] = ch;
      if (ch == pn_pkg::CH_DOT) begin
         if (seg_len == 0)
            dot_bits[0] = 1'b1;
         else if (seg_len == 1)
            dot_bits[1] = 1'b1;
      end
      if (seg_len < pn_pkg::PATH_BYTES)
         seg_len++;
   endfunction

   // a separator or the end of the path closes the current component
   function automatic void seg_close();
      int o;
      int clen;
      logic [1:0] dots;
      o    = norm_len;
      clen = seg_len;
      dots = dot_bits;
      seg_len  = 0;
      dot_bits = 2'b00;
      if (clen == 0)
         return;
      if (clen == 1 && dots[0])
         return;                           // "." is dropped
      if (clen == 2 && dots == 2'b11) begin
         // ".." cuts back to the previous component, stays put at root
         if (kept_depth > 0) begin
            kept_depth--;
            o = cut_stack[kept_depth];
            if (o < 1)
               o = 1;
            norm_len = o;
         end
         return;
      end
      if (kept_depth >= pn_pkg::MAX_DEPTH) begin
         path_bad = 1'b1;
         return;
      end
      if (o > 1) begin
         if (o + 1 >= pn_pkg::PATH_BYTES) begin
            path_bad = 1'b1;
            return;
         end
         norm_buf[o] = pn_pkg::CH_SLASH;
         o++;
      end
      cut_stack[kept_depth] = (o > 1) ? o - 1 : 1;
      kept_depth++;
      if (o + clen >= pn_pkg::PATH_BYTES) begin
         path_bad = 1'b1;
         return;
      end
      norm_len = o + clen;
   endfunction

   function automatic void predict_byte(logic [7:0] ch, logic last);
      if (!path_bad) begin
         if (ch == pn_pkg::CH_SLASH || ch == pn_pkg::CH_BSLASH)
            seg_close();
         else
            seg_add(ch);
      end
      if (!last)
         return;
      if (!path_bad)
         seg_close();
      if (path_bad) begin
         pending_path_bytes.push_back('{pn_pkg::CH_NONE, 1'b1, 1'b1});
      end else begin
         for (int k = 0; k < norm_len && k < pn_pkg::PATH_BYTES; k++)
            pending_path_bytes.push_back('{norm_buf[k], 1'b0, (k + 1 == norm_len)});
      end
      clear_norm_path();
   endfunction

   // ---------------- result side ----------------

   // stall in random bursts at the falling edge
   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_rsp
      path_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_path_bytes.size() == 0) begin
            flag_error($sformatf("unexpected result out_ch=%h error=%b final=%b",
                                 rsp_out_ch, rsp_error, rsp_final_res));
         end else begin
            want = pending_path_bytes.pop_front();
            if (rsp_out_ch !== want.out_ch)
               flag_error($sformatf("rsp_out_ch got %h want %h", rsp_out_ch, want.out_ch));
            if (rsp_error !== want.error)
               flag_error($sformatf("rsp_error got %b want %b", rsp_error, want.error));
            if (rsp_final_res !== want.fin)
               flag_error($sformatf("rsp_final_res got %b want %b",
                                    rsp_final_res, want.fin));
         end
      end
   end

   // ---------------- request side ----------------

   task automatic send_byte(logic [7:0] ch, logic last);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_ch    <= ch;
      req_last  <= last;
      do @(posedge clock); while (req_stall);
      predict_byte(ch, last);
   endtask

   task automatic send_path(path_q_type p);
      foreach (p[i])
         send_byte(p[i], i == p.size() - 1);
   endtask

   // hold off the sender until every expected byte is out
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_path_bytes.size() != 0)
         @(posedge clock);
   endtask

   function automatic path_q_type from_text(string s);
      path_q_type q;
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] sep_byte();
      return $urandom_range(0, 1) ? pn_pkg::CH_SLASH : pn_pkg::CH_BSLASH;
   endfunction

   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == pn_pkg::CH_SLASH || b == pn_pkg::CH_BSLASH);
      return b;
   endfunction

   // mostly well-formed paths with random names, dots and separator runs;
   // one in ten is raw noise
   function automatic path_q_type random_path();
      path_q_type p;
      int kind;
      int ncomp;
      int nlen;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         nlen = $urandom_range(1, 20);
         repeat (nlen)
            p.push_back($urandom_range(0, 3) == 0 ? sep_byte() : 8'($urandom_range(1, 255)));
         return p;
      end
      ncomp = (kind == 1) ? $urandom_range(20, 36) : $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0)
         p.push_back(sep_byte());
      for (int c = 0; c < ncomp; c++) begin
         if (c > 0)
            repeat ($urandom_range(1, 3)) p.push_back(sep_byte());
         case ($urandom_range(0, 9))
            0, 1: p.push_back(pn_pkg::CH_DOT);
            2, 3: begin
               p.push_back(pn_pkg::CH_DOT);
               p.push_back(pn_pkg::CH_DOT);
            end
            4: begin
               // names that start with a dot, "..." among them
               p.push_back(pn_pkg::CH_DOT);
               repeat ($urandom_range(1, 3))
                  p.push_back($urandom_range(0, 1) ? pn_pkg::CH_DOT : name_byte());
            end
            default: begin
               // rare long names run into the length limit and saturation
               nlen = ($urandom_range(0, 39) == 0) ? $urandom_range(55, 70)
                                                   : $urandom_range(1, 5);
               repeat (nlen) p.push_back(name_byte());
            end
         endcase
      end
      if ($urandom_range(0, 3) == 0)
         p.push_back(sep_byte());
      return p;
   endfunction

   // ---------------- tests ----------------

   task automatic test_separators();
      send_path(from_text("\\/a//b\\"));       // mixed runs collapse to "/a/b"
   endtask

   task automatic test_dot_rules();
      send_path(from_text("./../.x/..."));     // relative, dot, dotdot at root, dotted names
      send_path(from_text("a/b/.."));          // dotdot pops back to "/a"
   endtask

   task automatic test_empty_result();
      send_path(from_text("/"));
   endtask

   task automatic test_byte_extremes();
      path_q_type p;
      p = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F};   // byte zero counts as a name byte
      send_path(p);
   endtask

   // 31 one-byte components fit; the 32nd overruns the length limit,
   // which is hit before the depth check can trip
   task automatic test_depth_limit();
      path_q_type p;
      for (int n = 32; n <= 33; n++) begin
         p.delete();
         for (int c = 0; c < n; c++) begin
            p.push_back(sep_byte());
            p.push_back(name_byte());
         end
         if (n == 33) begin
            p.push_back(sep_byte());         // bytes after the error are ignored
            p.push_back(name_byte());
            p.push_back(pn_pkg::CH_DOT);
         end
         send_path(p);
      end
   endtask

   // a 62-byte name fills the buffer; one more slash overflows it;
   // a 70-byte name saturates the component counter
   task automatic test_length_limit();
      path_q_type p;
      repeat (62) p.push_back(name_byte());
      send_path(p);
      p.push_back(sep_byte());
      p.push_back(name_byte());
      send_path(p);
      p.delete();
      repeat (70) p.push_back(name_byte());
      send_path(p);
   endtask

   task automatic test_random_paths();
      path_q_type p;
      int mixed_items;
      bit paused;
      mixed_items = 0;
      paused = 1'b0;
      while (mixed_items < MIXED_ITEMS) begin
         if (!paused && mixed_items >= MIXED_ITEMS / 2) begin
            wait_for_results();
            paused = 1'b1;
         end
         if (mixed_items >= MIXED_ITEMS - 70)
            idle_on = 1'b0;                  // full rate to the end
         p = random_path();
         send_path(p);
         mixed_items += p.size();
      end
   endtask

   initial begin
      foreach (norm_buf[i])
         norm_buf[i] = 8'h00;
      foreach (cut_stack[i])
         cut_stack[i] = 0;
      clear_norm_path();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_separators();
      test_dot_rules();
      test_empty_result();
      test_byte_extremes();
      test_depth_limit();
      test_length_limit();
      test_random_paths();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_path_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_path_bytes.size() != 0)
         flag_error($sformatf("%0d bytes never arrived", pending_path_bytes.size()));

      if (error_count == 0) begin
         $display("path_normalizer_tb: done, clean");
      end else begin
         $display("path_normalizer_tb: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
src/pn_pkg.sv
src/pn_front.sv
src/pn_back.sv
src/path_normalizer.sv
src/pn_checker.sv
bench/path_normalizer_tb.sv
